@@ src/lstsf_pkg.sv @@
// Package for the LPC short-term synthesis filter: widths, micro-op codes,
// the control and status structs, the microprogram and the LAR dequantizer tables.
// Depends on nothing; lstsf_seq, lstsf_dp and the top level use it by scoped names.
`default_nettype none

package lstsf_pkg;

	localparam int unsigned NUM_STAGES = 8;
	localparam int unsigned IDX_W      = 3;
	localparam int unsigned BANK_AW    = 4;
	localparam int unsigned POS_W      = 8;
	localparam int unsigned PC_W       = 4;
	localparam int unsigned LAR_IDX_W  = 6;
	localparam int unsigned MUL_A_W    = 18;
	localparam int unsigned MUL_B_W    = 16;
	localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
	localparam int unsigned RND_W      = PROD_W - 15;
	localparam int unsigned WIDE_W     = 20;

	typedef logic signed [15:0] sample_t;

	// Frame positions where the reflection coefficients are rebuilt, and the last position of a frame.
	localparam logic [POS_W-1:0] POS_FIRST = 8'd0;
	localparam logic [POS_W-1:0] POS_SEG1  = 8'd13;
	localparam logic [POS_W-1:0] POS_SEG2  = 8'd27;
	localparam logic [POS_W-1:0] POS_SEG3  = 8'd40;
	localparam logic [POS_W-1:0] POS_LAST  = 8'd159;

	localparam logic signed [PROD_W-1:0]  ROUND_HALF = 34'sd16384;
	localparam logic signed [MUL_A_W-1:0] RC_KNEE1   = 18'sd11059;
	localparam logic signed [MUL_A_W-1:0] RC_KNEE2   = 18'sd20070;
	localparam logic signed [MUL_A_W-1:0] RC_BASE3   = 18'sd26112;
	localparam logic signed [WIDE_W-1:0]  S16_MAX    = 20'sd32767;
	localparam logic signed [WIDE_W-1:0]  S16_MIN    = -20'sd32768;

	typedef enum logic [3:0] {
		UOP_NOP,
		UOP_DQ_MUL,
		UOP_DQ_WR,
		UOP_CF_RDA,
		UOP_CF_RDB,
		UOP_CF_WR,
		UOP_LT_MUL_V,
		UOP_LT_SUB,
		UOP_LT_MUL_S,
		UOP_LT_UPD,
		UOP_DONE
	} uop_t;

	typedef enum logic [2:0] {
		COND_NONE,
		COND_ALWAYS,
		COND_NO_INPUT,
		COND_NOT_FRAME_START,
		COND_NO_COEF,
		COND_MORE,
		COND_OUT_BUSY
	} cond_t;

	typedef enum logic [1:0] {
		IDX_HOLD,
		IDX_CLR,
		IDX_INC
	} idx_op_t;

	typedef struct packed {
		uop_t            op;
		cond_t           cond;
		logic [PC_W-1:0] target;
		idx_op_t         idx_op;
	} ucode_t;

	typedef struct packed {
		uop_t             op;
		logic [IDX_W-1:0] idx;
		logic             take;
	} dp_ctrl_t;

	typedef struct packed {
		logic frame_start;
		logic coef_due;
	} dp_stat_t;

	localparam logic [PC_W-1:0] STEP_IDLE     = 4'd0;
	localparam logic [PC_W-1:0] STEP_DISPATCH = 4'd1;
	localparam logic [PC_W-1:0] STEP_DQ_MUL   = 4'd2;
	localparam logic [PC_W-1:0] STEP_DQ_WR    = 4'd3;
	localparam logic [PC_W-1:0] STEP_CF_CHECK = 4'd4;
	localparam logic [PC_W-1:0] STEP_CF_RDA   = 4'd5;
	localparam logic [PC_W-1:0] STEP_CF_RDB   = 4'd6;
	localparam logic [PC_W-1:0] STEP_CF_WR    = 4'd7;
	localparam logic [PC_W-1:0] STEP_LT_MUL_V = 4'd8;
	localparam logic [PC_W-1:0] STEP_LT_SUB   = 4'd9;
	localparam logic [PC_W-1:0] STEP_LT_MUL_S = 4'd10;
	localparam logic [PC_W-1:0] STEP_LT_UPD   = 4'd11;
	localparam logic [PC_W-1:0] STEP_WAIT     = 4'd12;
	localparam logic [PC_W-1:0] STEP_DONE     = 4'd13;

	// The microprogram. A taken jump goes to target, otherwise the step counter
	// advances. Loop steps test the index before it is incremented.
	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		unique case (pc)
			STEP_IDLE:     w = '{UOP_NOP,      COND_NO_INPUT,        STEP_IDLE,     IDX_CLR};
			STEP_DISPATCH: w = '{UOP_NOP,      COND_NOT_FRAME_START, STEP_CF_CHECK, IDX_CLR};
			STEP_DQ_MUL:   w = '{UOP_DQ_MUL,   COND_NONE,            STEP_IDLE,     IDX_HOLD};
			STEP_DQ_WR:    w = '{UOP_DQ_WR,    COND_MORE,            STEP_DQ_MUL,   IDX_INC};
			STEP_CF_CHECK: w = '{UOP_NOP,      COND_NO_COEF,         STEP_LT_MUL_V, IDX_CLR};
			STEP_CF_RDA:   w = '{UOP_CF_RDA,   COND_NONE,            STEP_IDLE,     IDX_HOLD};
			STEP_CF_RDB:   w = '{UOP_CF_RDB,   COND_NONE,            STEP_IDLE,     IDX_HOLD};
			STEP_CF_WR:    w = '{UOP_CF_WR,    COND_MORE,            STEP_CF_RDA,   IDX_INC};
			STEP_LT_MUL_V: w = '{UOP_LT_MUL_V, COND_NONE,            STEP_IDLE,     IDX_HOLD};
			STEP_LT_SUB:   w = '{UOP_LT_SUB,   COND_NONE,            STEP_IDLE,     IDX_HOLD};
			STEP_LT_MUL_S: w = '{UOP_LT_MUL_S, COND_NONE,            STEP_IDLE,     IDX_HOLD};
			STEP_LT_UPD:   w = '{UOP_LT_UPD,   COND_MORE,            STEP_LT_MUL_V, IDX_INC};
			STEP_WAIT:     w = '{UOP_NOP,      COND_OUT_BUSY,        STEP_WAIT,     IDX_HOLD};
			STEP_DONE:     w = '{UOP_DONE,     COND_ALWAYS,          STEP_IDLE,     IDX_CLR};
			default:       w = '{UOP_NOP,      COND_ALWAYS,          STEP_IDLE,     IDX_CLR};
		endcase
		return w;
	endfunction

	// Dequantizer offset: index minimum times 1024 less twice the LAR offset.
	function automatic logic signed [MUL_A_W-1:0] dq_bias(input logic [IDX_W-1:0] i);
		logic signed [MUL_A_W-1:0] v;
		unique case (i)
			3'd0:    v = -18'sd32768;
			3'd1:    v = -18'sd32768;
			3'd2:    v = -18'sd20480;
			3'd3:    v = -18'sd11264;
			3'd4:    v = -18'sd8380;
			3'd5:    v = -18'sd4608;
			3'd6:    v = -18'sd3414;
			default: v = -18'sd1808;
		endcase
		return v;
	endfunction

	function automatic logic signed [MUL_B_W-1:0] dq_scale(input logic [IDX_W-1:0] i);
		logic signed [MUL_B_W-1:0] v;
		unique case (i)
			3'd0:    v = 16'sd13107;
			3'd1:    v = 16'sd13107;
			3'd2:    v = 16'sd13107;
			3'd3:    v = 16'sd13107;
			3'd4:    v = 16'sd19223;
			3'd5:    v = 16'sd17476;
			3'd6:    v = 16'sd31454;
			default: v = 16'sd29708;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

@@ src/lstsf_seq.sv @@
// Microcode sequencer: step counter, program table lookup, jump conditions
// and the loop index. Depends on lstsf_pkg.
`default_nettype none

module lstsf_seq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	input  wire logic                result_busy,
	input  wire lstsf_pkg::dp_stat_t stat,
	output lstsf_pkg::dp_ctrl_t      ctrl,
	output logic                     idle,
	output logic                     done
);

	logic [lstsf_pkg::PC_W-1:0]  pc_q;
	logic [lstsf_pkg::PC_W-1:0]  pc_d;
	logic [lstsf_pkg::IDX_W-1:0] idx_q;
	logic [lstsf_pkg::IDX_W-1:0] idx_d;
	lstsf_pkg::ucode_t           uw;
	logic                        jump;

	assign uw = lstsf_pkg::ucode_rom(pc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= lstsf_pkg::STEP_IDLE;
			idx_q <= '0;
		end else begin
			pc_q  <= pc_d;
			idx_q <= idx_d;
		end
	end

	always_comb begin
		unique case (uw.cond)
			lstsf_pkg::COND_NONE:            jump = 1'b0;
			lstsf_pkg::COND_ALWAYS:          jump = 1'b1;
			lstsf_pkg::COND_NO_INPUT:        jump = !item_valid;
			lstsf_pkg::COND_NOT_FRAME_START: jump = !stat.frame_start;
			lstsf_pkg::COND_NO_COEF:         jump = !stat.coef_due;
			lstsf_pkg::COND_MORE:            jump = (idx_q != {lstsf_pkg::IDX_W{1'b1}});
			lstsf_pkg::COND_OUT_BUSY:        jump = result_busy;
			default:                         jump = 1'b1;
		endcase
		pc_d = jump ? uw.target : pc_q + 1'b1;

		unique case (uw.idx_op)
			lstsf_pkg::IDX_CLR: idx_d = '0;
			lstsf_pkg::IDX_INC: idx_d = idx_q + 1'b1;
			default:            idx_d = idx_q;
		endcase

		idle      = (pc_q == lstsf_pkg::STEP_IDLE);
		done      = (uw.op == lstsf_pkg::UOP_DONE);
		ctrl.op   = uw.op;
		ctrl.idx  = idx_q;
		ctrl.take = idle && item_valid;
	end

endmodule

`default_nettype wire

@@ src/lstsf_dp.sv @@
// Datapath: shared multiplier with rounding, LAR banks, reflection
// coefficients and lattice stage memories. Driven step by step by lstsf_seq.
// Depends on lstsf_pkg.
`default_nettype none

module lstsf_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lstsf_pkg::dp_ctrl_t  ctrl,
	input  wire lstsf_pkg::sample_t   residual_sample,
	input  wire logic [5:0]           lar_index_1,
	input  wire logic [5:0]           lar_index_2,
	input  wire logic [4:0]           lar_index_3,
	input  wire logic [4:0]           lar_index_4,
	input  wire logic [3:0]           lar_index_5,
	input  wire logic [3:0]           lar_index_6,
	input  wire logic [2:0]           lar_index_7,
	input  wire logic [2:0]           lar_index_8,
	output lstsf_pkg::dp_stat_t       stat,
	output lstsf_pkg::sample_t        result
);

	localparam int unsigned NS = lstsf_pkg::NUM_STAGES;
	localparam int unsigned IW = lstsf_pkg::IDX_W;

	lstsf_pkg::sample_t lat_q  [NS];
	lstsf_pkg::sample_t rc_q   [NS];
	lstsf_pkg::sample_t bank_q [2*NS];
	logic [lstsf_pkg::LAR_IDX_W-1:0] lar_idx_q [NS];
	logic [lstsf_pkg::POS_W-1:0]     pos_q;
	logic                            bank_sel_q;

	lstsf_pkg::sample_t                       sri_q;
	lstsf_pkg::sample_t                       a_q;
	logic signed [lstsf_pkg::MUL_A_W-1:0]     p_q;
	logic signed [lstsf_pkg::PROD_W-1:0]      prod_q;

	logic [IW-1:0]                            stage;
	logic [IW-1:0]                            stage_up;
	logic [lstsf_pkg::BANK_AW-1:0]            rd_addr;
	lstsf_pkg::sample_t                       rd_data;
	logic signed [lstsf_pkg::MUL_A_W-1:0]     mul_a;
	logic signed [lstsf_pkg::MUL_B_W-1:0]     mul_b;
	logic signed [lstsf_pkg::PROD_W-1:0]      rnd_sum;
	logic signed [lstsf_pkg::RND_W-1:0]       rnd;
	logic signed [lstsf_pkg::MUL_A_W-1:0]     p_mix;
	logic signed [lstsf_pkg::MUL_A_W-1:0]     la;
	logic signed [lstsf_pkg::MUL_A_W-1:0]     lb;

	function automatic lstsf_pkg::sample_t sat16(input logic signed [lstsf_pkg::WIDE_W-1:0] x);
		lstsf_pkg::sample_t r;
		if (x > lstsf_pkg::S16_MAX) begin
			r = 16'sh7fff;
		end else if (x < lstsf_pkg::S16_MIN) begin
			r = 16'sh8000;
		end else begin
			r = x[15:0];
		end
		return r;
	endfunction

	// Piecewise LAR to reflection coefficient map, applied to the magnitude.
	function automatic lstsf_pkg::sample_t lar_to_rc(input logic signed [lstsf_pkg::MUL_A_W-1:0] p);
		logic signed [lstsf_pkg::MUL_A_W-1:0] m;
		logic signed [lstsf_pkg::WIDE_W-1:0]  r;
		lstsf_pkg::sample_t                   s;
		m = p[lstsf_pkg::MUL_A_W-1] ? -p : p;
		if (m < lstsf_pkg::RC_KNEE1) begin
			r = {m[lstsf_pkg::MUL_A_W-1], m, 1'b0};
		end else if (m < lstsf_pkg::RC_KNEE2) begin
			r = lstsf_pkg::WIDE_W'(m) + lstsf_pkg::WIDE_W'(lstsf_pkg::RC_KNEE1);
		end else begin
			r = lstsf_pkg::WIDE_W'(m >>> 2) + lstsf_pkg::WIDE_W'(lstsf_pkg::RC_BASE3);
		end
		s = sat16(r);
		return p[lstsf_pkg::MUL_A_W-1] ? -s : s;
	endfunction

	// The lattice runs from the top stage down while the index counts up.
	assign stage    = ~ctrl.idx;
	assign stage_up = stage + 1'b1;

	assign rd_addr = {(ctrl.op == lstsf_pkg::UOP_CF_RDA) ? ~bank_sel_q : bank_sel_q, ctrl.idx};
	assign rd_data = bank_q[rd_addr];

	assign rnd_sum = prod_q + lstsf_pkg::ROUND_HALF;
	assign rnd     = rnd_sum[lstsf_pkg::PROD_W-1:15];

	assign stat.frame_start = (pos_q == lstsf_pkg::POS_FIRST);
	assign stat.coef_due    = (pos_q == lstsf_pkg::POS_FIRST) || (pos_q == lstsf_pkg::POS_SEG1)
		|| (pos_q == lstsf_pkg::POS_SEG2) || (pos_q == lstsf_pkg::POS_SEG3);
	assign result = sri_q;

	always_comb begin
		unique case (ctrl.op)
			lstsf_pkg::UOP_DQ_MUL: begin
				mul_a = lstsf_pkg::dq_bias(ctrl.idx)
					+ $signed(lstsf_pkg::MUL_A_W'({lar_idx_q[ctrl.idx], 10'b0}));
				mul_b = lstsf_pkg::dq_scale(ctrl.idx);
			end
			lstsf_pkg::UOP_LT_MUL_S: begin
				mul_a = lstsf_pkg::MUL_A_W'(rc_q[stage]);
				mul_b = sri_q;
			end
			default: begin
				mul_a = lstsf_pkg::MUL_A_W'(rc_q[stage]);
				mul_b = lat_q[stage];
			end
		endcase

		// Interpolation between the previous frame's LAR (la) and the new one (lb).
		la = lstsf_pkg::MUL_A_W'(a_q);
		lb = lstsf_pkg::MUL_A_W'(rd_data);
		priority if (pos_q == lstsf_pkg::POS_FIRST) begin
			p_mix = (la >>> 1) + (la >>> 2) + (lb >>> 2);
		end else if (pos_q == lstsf_pkg::POS_SEG1) begin
			p_mix = (la >>> 1) + (lb >>> 1);
		end else if (pos_q == lstsf_pkg::POS_SEG2) begin
			p_mix = (lb >>> 1) + (la >>> 2) + (lb >>> 2);
		end else begin
			p_mix = lb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) begin
				lat_q[i] <= '0;
				rc_q[i]  <= '0;
			end
			for (int i = 0; i < 2*NS; i++) begin
				bank_q[i] <= '0;
			end
			pos_q      <= '0;
			bank_sel_q <= 1'b0;
		end else begin
			unique case (ctrl.op)
				lstsf_pkg::UOP_DQ_WR: begin
					bank_q[{bank_sel_q, ctrl.idx}] <=
						sat16(lstsf_pkg::WIDE_W'(rnd) + lstsf_pkg::WIDE_W'(rnd));
				end
				lstsf_pkg::UOP_CF_WR: begin
					rc_q[ctrl.idx] <= lar_to_rc(p_q);
				end
				lstsf_pkg::UOP_LT_UPD: begin
					// The top stage's update has no memory to land in.
					if (stage != IW'(NS-1)) begin
						lat_q[stage_up] <=
							sat16(lstsf_pkg::WIDE_W'(lat_q[stage]) + lstsf_pkg::WIDE_W'(rnd));
					end
				end
				lstsf_pkg::UOP_DONE: begin
					lat_q[0] <= sri_q;
					if (pos_q == lstsf_pkg::POS_LAST) begin
						pos_q      <= '0;
						bank_sel_q <= ~bank_sel_q;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			sri_q        <= residual_sample;
			lar_idx_q[0] <= lar_index_1;
			lar_idx_q[1] <= lar_index_2;
			lar_idx_q[2] <= lstsf_pkg::LAR_IDX_W'(lar_index_3);
			lar_idx_q[3] <= lstsf_pkg::LAR_IDX_W'(lar_index_4);
			lar_idx_q[4] <= lstsf_pkg::LAR_IDX_W'(lar_index_5);
			lar_idx_q[5] <= lstsf_pkg::LAR_IDX_W'(lar_index_6);
			lar_idx_q[6] <= lstsf_pkg::LAR_IDX_W'(lar_index_7);
			lar_idx_q[7] <= lstsf_pkg::LAR_IDX_W'(lar_index_8);
		end
		unique case (ctrl.op)
			lstsf_pkg::UOP_DQ_MUL, lstsf_pkg::UOP_LT_MUL_V, lstsf_pkg::UOP_LT_MUL_S: begin
				prod_q <= lstsf_pkg::PROD_W'(mul_a) * lstsf_pkg::PROD_W'(mul_b);
			end
			lstsf_pkg::UOP_CF_RDA: begin
				a_q <= rd_data;
			end
			lstsf_pkg::UOP_CF_RDB: begin
				p_q <= p_mix;
			end
			lstsf_pkg::UOP_LT_SUB: begin
				sri_q <= sat16(lstsf_pkg::WIDE_W'(sri_q) - lstsf_pkg::WIDE_W'(rnd));
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

@@ src/lpc_short_term_synthesis_filter.sv @@
// LPC short-term synthesis filter (8-stage lattice) for 160-sample frames.
// Input channel residual_*: one residual sample per beat; the eight LAR indices are
// used only on the first beat of each frame and ignored on the other 159.
// Output channel speech_*: one reconstructed, saturated speech sample per input beat,
// in order. Both channels use valid/stall; a beat moves when valid is high and
// stall is low.
// One item is processed at a time by a microcoded sequencer over one shared
// 18x16 multiplier. Frame positions 13, 27 and 40 add a coefficient rebuild, and
// the first sample of a frame adds LAR dequantization plus the rebuild. The
// lattice loop runs four steps per stage through the shared multiplier, and the
// next input beat is taken only once the sequencer is back in its idle step.
// The finished sample sits in an output register, so the next input beat is taken
// while it waits. If speech_stall holds that sample until the next one is done,
// the sequencer waits at its wait step before the final one and residual_stall stays high.
// Reset clears the stage memories, both LAR banks, the coefficients, the frame
// position and the bank select; the first frame interpolates against zero LARs.
`default_nettype none

module lpc_short_term_synthesis_filter (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                residual_valid,
	output logic                     residual_stall,
	input  wire lstsf_pkg::sample_t  residual_sample,
	input  wire logic [5:0]          lar_index_1,
	input  wire logic [5:0]          lar_index_2,
	input  wire logic [4:0]          lar_index_3,
	input  wire logic [4:0]          lar_index_4,
	input  wire logic [3:0]          lar_index_5,
	input  wire logic [3:0]          lar_index_6,
	input  wire logic [2:0]          lar_index_7,
	input  wire logic [2:0]          lar_index_8,
	output logic                     speech_valid,
	input  wire logic                speech_stall,
	output lstsf_pkg::sample_t       speech_sample
);

	lstsf_pkg::dp_ctrl_t ctrl;
	lstsf_pkg::dp_stat_t stat;
	lstsf_pkg::sample_t  result;
	logic                idle;
	logic                done;
	logic                speech_valid_q;
	lstsf_pkg::sample_t  speech_q;
	logic                result_busy;

	assign result_busy    = speech_valid_q && speech_stall;
	assign residual_stall = !idle;
	assign speech_valid   = speech_valid_q;
	assign speech_sample  = speech_q;

	lstsf_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (residual_valid),
		.result_busy (result_busy),
		.stat        (stat),
		.ctrl        (ctrl),
		.idle        (idle),
		.done        (done)
	);

	lstsf_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl            (ctrl),
		.residual_sample (residual_sample),
		.lar_index_1     (lar_index_1),
		.lar_index_2     (lar_index_2),
		.lar_index_3     (lar_index_3),
		.lar_index_4     (lar_index_4),
		.lar_index_5     (lar_index_5),
		.lar_index_6     (lar_index_6),
		.lar_index_7     (lar_index_7),
		.lar_index_8     (lar_index_8),
		.stat            (stat),
		.result          (result)
	);

	// The sequencer only reaches its final step once this register is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speech_valid_q <= 1'b0;
		end else if (done) begin
			speech_valid_q <= 1'b1;
		end else if (!speech_stall) begin
			speech_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			speech_q <= result;
		end
	end

endmodule

`default_nettype wire

@@ src/lstsf_checker.sv @@
// Port-level checks for lpc_short_term_synthesis_filter, attached by the bind
// at the end of this file. Depends on the top level's port list only.
`default_nettype none

module lstsf_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               residual_valid,
	input wire logic               residual_stall,
	input wire logic               speech_valid,
	input wire logic               speech_stall,
	input wire logic signed [15:0] speech_sample
);

	// An item is worked through the sequencer's steps, so the input side stays stalled after a beat.
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(residual_valid && !residual_stall) |=> residual_stall ##1 residual_stall)
		else $error("input taken again too soon after a beat");

	// A new result only appears while an item is being worked on.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(speech_valid) |-> $past(residual_stall))
		else $error("result appeared with no item in work");

	// A result is never loaded in the same cycle as the previous one leaves.
	a_gap_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(speech_valid && !speech_stall) |=> !speech_valid)
		else $error("result register reloaded while draining");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(speech_valid && speech_stall) |=> speech_valid && $stable(speech_sample))
		else $error("stalled result beat changed");

endmodule

bind lpc_short_term_synthesis_filter lstsf_checker u_lstsf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.residual_valid (residual_valid),
	.residual_stall (residual_stall),
	.speech_valid   (speech_valid),
	.speech_stall   (speech_stall),
	.speech_sample  (speech_sample)
);

`default_nettype wire
